[src/yrpc_pkg.sv]
// ----------------------------------------------------------------------------
// yrpc_pkg: shared types and constants of the YUV/RGB pixel converter
// Conversion modes, fixed-point coefficients (16 fraction bits) and the
// per-mode coefficient matrix used by the multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

package yrpc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned CountW = 2;
  localparam int unsigned CoefW  = 19;
  localparam int unsigned ProdW  = CoefW + ByteW + 1;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned FracW  = 16;
  localparam int unsigned NumCoef = 9;

  typedef enum logic [ModeW-1:0] {
    MODE_YUV_RGB24  = 3'd0,
    MODE_YUV_RGB565 = 3'd1,
    MODE_YUV_RGB8   = 3'd2,
    MODE_YUV_GRAY   = 3'd3,
    MODE_RGB_YUV    = 3'd4,
    MODE_RGB_RGB565 = 3'd5,
    MODE_RGB_RGB8   = 3'd6
  } mode_t;

  localparam logic [CountW-1:0] COUNT_ONE   = 2'd1;
  localparam logic [CountW-1:0] COUNT_TWO   = 2'd2;
  localparam logic [CountW-1:0] COUNT_THREE = 2'd3;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef coef_t coef_mat_t [NumCoef];
  typedef logic signed [SumW-1:0] sum_t;

  localparam coef_t K_ONE = 19'sd65536;
  localparam coef_t K_V_R = 19'sd83908;
  localparam coef_t K_U_G = 19'sd14078;
  localparam coef_t K_V_G = 19'sd24942;
  localparam coef_t K_U_B = 19'sd139459;
  localparam coef_t K_R_Y = 19'sd13933;
  localparam coef_t K_G_Y = 19'sd46871;
  localparam coef_t K_B_Y = 19'sd4732;
  localparam coef_t K_R_U = 19'sd6548;
  localparam coef_t K_G_U = 19'sd22026;
  localparam coef_t K_B_U = 19'sd28574;
  localparam coef_t K_R_V = 19'sd40305;
  localparam coef_t K_G_V = 19'sd36609;
  localparam coef_t K_B_V = 19'sd3696;
  localparam coef_t K_ZERO = 19'sd0;

  // Rows are output components, columns are the three input bytes.
  // Gray pass-through and the RGB-input packing modes use the identity matrix so the clamp
  // returns the input bytes unchanged.
  function automatic coef_mat_t coef_set(mode_t mode);
    coef_mat_t k;
    case (mode)
      MODE_YUV_RGB24, MODE_YUV_RGB565, MODE_YUV_RGB8: begin
        k = '{K_ONE, K_ZERO, K_V_R,
              K_ONE, -K_U_G, -K_V_G,
              K_ONE, K_U_B,  K_ZERO};
      end
      MODE_YUV_GRAY, MODE_RGB_RGB565, MODE_RGB_RGB8: begin
        k = '{K_ONE,  K_ZERO, K_ZERO,
              K_ZERO, K_ONE,  K_ZERO,
              K_ZERO, K_ZERO, K_ONE};
      end
      MODE_RGB_YUV: begin
        k = '{K_R_Y,  K_G_Y,  K_B_Y,
              -K_R_U, -K_G_U, K_B_U,
              K_R_V,  -K_G_V, -K_B_V};
      end
      default: begin
        k = '{K_ZERO, K_ZERO, K_ZERO,
              K_ZERO, K_ZERO, K_ZERO,
              K_ZERO, K_ZERO, K_ZERO};
      end
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[src/yuv_rgb_pixel_converter_unit.sv]
// An accepted request passes the stage 1, 2, 3 and output registers.
// One pixel per cycle while out_ready allows; the four stages each advance
// on their own, so bubbles close up and a full pipeline holds four requests.
// The nine coefficient products set the stage depth (19x9 signed each).
// Reset clears all stage valid bits and sets conversion_mode to 0.
// ----------------------------------------------------------------------------
// yuv_rgb_pixel_converter_unit: pipelined YUV/RGB pixel converter
// Stage 1 registers the pixel and its coefficient matrix, stage 2 forms the
// products, stage 3 the sums, stage 4 clamps, packs and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_rgb_pixel_converter_unit (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               conversion_mode_we,
  input  wire  [yrpc_pkg::ModeW-1:0]        conversion_mode_wdata,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [yrpc_pkg::ByteW-1:0]        comp_first,
  input  wire  [yrpc_pkg::ByteW-1:0]        comp_second,
  input  wire  [yrpc_pkg::ByteW-1:0]        comp_third,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [yrpc_pkg::ByteW-1:0]        out_byte0,
  output logic [yrpc_pkg::ByteW-1:0]        out_byte1,
  output logic [yrpc_pkg::ByteW-1:0]        out_byte2,
  output logic [yrpc_pkg::CountW-1:0]       out_count
);

  localparam int unsigned NumCoef = yrpc_pkg::NumCoef;

  yrpc_pkg::mode_t conversion_mode;

  // stage 1: pixel bytes and coefficients
  logic                         v1;
  yrpc_pkg::mode_t              mode1;
  yrpc_pkg::coef_mat_t          coef1;
  logic [yrpc_pkg::ByteW-1:0]   pix1 [3];
  // stage 2: products
  logic                         v2;
  yrpc_pkg::mode_t              mode2;
  logic signed [yrpc_pkg::ProdW-1:0] prod2 [NumCoef];
  // stage 3: sums
  logic                         v3;
  yrpc_pkg::mode_t              mode3;
  yrpc_pkg::sum_t               sum3 [3];

  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;

  yrpc_pkg::coef_mat_t          coef_next;
  logic [yrpc_pkg::ByteW-1:0]   fmt_byte0;
  logic [yrpc_pkg::ByteW-1:0]   fmt_byte1;
  logic [yrpc_pkg::ByteW-1:0]   fmt_byte2;
  logic [yrpc_pkg::CountW-1:0]  fmt_count;

  // a stage takes a new request when empty or when its content moves on
  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign coef_next = yrpc_pkg::coef_set(conversion_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_mode <= yrpc_pkg::MODE_YUV_RGB24;
    end else if (conversion_mode_we) begin
      conversion_mode <= yrpc_pkg::mode_t'(conversion_mode_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      mode1   <= conversion_mode;
      coef1   <= coef_next;
      pix1[0] <= comp_first;
      pix1[1] <= comp_second;
      pix1[2] <= comp_third;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      mode2 <= mode1;
      for (int i = 0; i < NumCoef; i++) begin
        prod2[i] <= coef1[i] * $signed({1'b0, pix1[i % 3]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      mode3 <= mode2;
      for (int k = 0; k < 3; k++) begin
        sum3[k] <= yrpc_pkg::SumW'(prod2[3*k]) + yrpc_pkg::SumW'(prod2[3*k+1])
                   + yrpc_pkg::SumW'(prod2[3*k+2]);
      end
    end
  end

  yrpc_format u_format (
    .mode  (mode3),
    .sum0  (sum3[0]),
    .sum1  (sum3[1]),
    .sum2  (sum3[2]),
    .byte0 (fmt_byte0),
    .byte1 (fmt_byte1),
    .byte2 (fmt_byte2),
    .count (fmt_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
    if (rdy4 && v3) begin
      out_byte0 <= fmt_byte0;
      out_byte1 <= fmt_byte1;
      out_byte2 <= fmt_byte2;
      out_count <= fmt_count;
    end
  end

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count != 2'd0)
    else $error("result with zero byte count");

  a_unused_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_count == yrpc_pkg::COUNT_TWO |-> out_byte2 == '0)
    else $error("unused third byte not zero");

  a_unused_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_count == yrpc_pkg::COUNT_ONE |-> out_byte1 == '0 && out_byte2 == '0)
    else $error("unused bytes not zero");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    v3 && rdy4 |=> out_valid)
    else $error("request lost between sum and output stage");

endmodule

`default_nettype wire

[src/yrpc_format.sv]
// ----------------------------------------------------------------------------
// yrpc_format: clamp and output packing
// Turns three fixed-point sums into bytes (negative to 0, truncate, clamp
// to 255) and arranges them per mode as RGB24/YUV, RGB565, RGB8 or gray.
// ----------------------------------------------------------------------------
`default_nettype none

module yrpc_format (
  input  wire yrpc_pkg::mode_t                 mode,
  input  wire yrpc_pkg::sum_t                  sum0,
  input  wire yrpc_pkg::sum_t                  sum1,
  input  wire yrpc_pkg::sum_t                  sum2,
  output logic [yrpc_pkg::ByteW-1:0]           byte0,
  output logic [yrpc_pkg::ByteW-1:0]           byte1,
  output logic [yrpc_pkg::ByteW-1:0]           byte2,
  output logic [yrpc_pkg::CountW-1:0]          count
);

  localparam int unsigned WholeW = yrpc_pkg::SumW - yrpc_pkg::FracW;

  function automatic logic [yrpc_pkg::ByteW-1:0] clamp(yrpc_pkg::sum_t s);
    logic [WholeW-1:0] whole;
    logic [yrpc_pkg::ByteW-1:0] res;
    whole = s[yrpc_pkg::SumW-1:yrpc_pkg::FracW];
    if (s[yrpc_pkg::SumW-1]) begin
      res = '0;
    end else if (whole[WholeW-1:yrpc_pkg::ByteW] != '0) begin
      res = '1;
    end else begin
      res = whole[yrpc_pkg::ByteW-1:0];
    end
    return res;
  endfunction

  logic [yrpc_pkg::ByteW-1:0] r;
  logic [yrpc_pkg::ByteW-1:0] g;
  logic [yrpc_pkg::ByteW-1:0] b;

  assign r = clamp(sum0);
  assign g = clamp(sum1);
  assign b = clamp(sum2);

  always_comb begin
    byte0 = '0;
    byte1 = '0;
    byte2 = '0;
    count = yrpc_pkg::COUNT_ONE;
    case (mode)
      yrpc_pkg::MODE_YUV_RGB24, yrpc_pkg::MODE_RGB_YUV: begin
        byte0 = r;
        byte1 = g;
        byte2 = b;
        count = yrpc_pkg::COUNT_THREE;
      end
      yrpc_pkg::MODE_YUV_RGB565, yrpc_pkg::MODE_RGB_RGB565: begin
        byte0 = {g[2:0], r[4:0]};
        byte1 = {b[4:0], g[5:3]};
        count = yrpc_pkg::COUNT_TWO;
      end
      yrpc_pkg::MODE_YUV_RGB8, yrpc_pkg::MODE_RGB_RGB8: begin
        byte0 = {b[1:0], g[2:0], r[2:0]};
      end
      yrpc_pkg::MODE_YUV_GRAY: begin
        byte0 = r;
      end
      default: begin
        byte0 = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
